// ----- sv/cdeb_pkg.sv -----
`timescale 1ns / 1ps
// Types, constants and result builders for the configuration descriptor
// endpoint builder. No dependencies.
package cdeb_pkg;

  localparam logic [7:0] TypeIface     = 8'h04;
  localparam logic [7:0] TypeEndpoint  = 8'h05;
  localparam logic [7:0] TypeCompanion = 8'h30;
  localparam logic [7:0] ClassHub      = 8'h09;
  localparam logic [1:0] XferIsoch     = 2'h1;
  localparam logic [3:0] SpeedFull     = 4'h1;
  localparam logic [3:0] SpeedLow      = 4'h2;
  localparam logic [3:0] SpeedSuper    = 4'h4;

  typedef enum logic [1:0] {
    CfgPortSpeed   = 2'd0,
    CfgDeviceClass = 2'd1,
    CfgRouteString = 2'd2,
    CfgUnused      = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    CompIdle   = 2'd0,
    CompLength = 2'd1,
    CompType   = 2'd2,
    CompBurst  = 2'd3
  } comp_stage_e;

  typedef struct packed {
    logic        kind;
    logic        run_last;
    logic [4:0]  ep_dci;
    logic [31:0] ep_info1;
    logic [31:0] ep_info2;
    logic [31:0] ep_tx_info;
    logic [31:0] ctx_add_mask;
    logic [4:0]  max_index;
    logic        hub_flag;
    logic [31:0] slot_info1;
    logic [3:0]  interface_total;
  } res_t;

  typedef struct packed {
    logic [1:0] count;
    res_t       rec0;
    res_t       rec1;
  } push_t;

  function automatic res_t mk_ep(logic [4:0] dci, logic [31:0] i1, logic [31:0] i2,
                                 logic [31:0] tx);
    res_t r;
    r = '0;
    r.ep_dci     = dci;
    r.ep_info1   = i1;
    r.ep_info2   = i2;
    r.ep_tx_info = tx;
    return r;
  endfunction

  function automatic res_t mk_sum(logic [31:0] flags, logic [4:0] top, logic hub,
                                  logic [3:0] speed, logic [19:0] route,
                                  logic [3:0] ifaces);
    res_t r;
    r = '0;
    r.kind            = 1'b1;
    r.ctx_add_mask    = flags;
    r.max_index       = top;
    r.hub_flag        = hub;
    r.slot_info1      = {top, hub, 2'b00, speed, route};
    r.interface_total = ifaces;
    return r;
  endfunction

endpackage

// ----- sv/config_descriptor_endpoint_builder_top.sv -----
`timescale 1ns / 1ps
// Top level of the configuration descriptor endpoint builder.
// Depends on cdeb_pkg, cdeb_front, cdeb_queue and cdeb_back.
//
// Takes one configuration descriptor byte per cycle and turns endpoint descriptors
// into xHCI endpoint context words, then a slot summary on the final byte. A byte
// is parsed in the cycle it is taken; its zero to two results enter a four-entry
// queue and leave through an output register one per cycle while the output is not
// stalled. Input is stalled only while the queue holds more than two results. At
// SuperSpeed an endpoint leaves after the companion's length, type or burst byte
// settles its burst. Write configuration while idle.
module config_descriptor_endpoint_builder_top #(
  parameter int MaxIfaces = 8,
  parameter int MaxEps    = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [19:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  desc_byte_i,
  input  logic        final_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        kind_o,
  output logic        run_last_o,
  output logic [4:0]  ep_dci_o,
  output logic [31:0] ep_info1_o,
  output logic [31:0] ep_info2_o,
  output logic [31:0] ep_tx_info_o,
  output logic [31:0] ctx_add_mask_o,
  output logic [4:0]  max_index_o,
  output logic        hub_flag_o,
  output logic [31:0] slot_info1_o,
  output logic [3:0]  interface_total_o
);

  cdeb_pkg::push_t push;
  cdeb_pkg::res_t  head;
  cdeb_pkg::res_t  res;
  logic            room;
  logic            avail;
  logic            pop;
  logic            accept;

  assign in_stall_o = !room;
  assign accept     = in_valid_i && room;

  cdeb_front #(
    .MaxIfaces(MaxIfaces),
    .MaxEps   (MaxEps)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .accept_i    (accept),
    .desc_byte_i (desc_byte_i),
    .final_byte_i(final_byte_i),
    .push_o      (push)
  );

  cdeb_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .room_o (room),
    .pop_i  (pop),
    .avail_o(avail),
    .head_o (head)
  );

  cdeb_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .avail_i(avail),
    .head_i (head),
    .pop_o  (pop),
    .valid_o(out_valid_o),
    .stall_i(out_stall_i),
    .res_o  (res)
  );

  assign kind_o            = res.kind;
  assign run_last_o        = res.run_last;
  assign ep_dci_o          = res.ep_dci;
  assign ep_info1_o        = res.ep_info1;
  assign ep_info2_o        = res.ep_info2;
  assign ep_tx_info_o      = res.ep_tx_info;
  assign ctx_add_mask_o    = res.ctx_add_mask;
  assign max_index_o       = res.max_index;
  assign hub_flag_o        = res.hub_flag;
  assign slot_info1_o      = res.slot_info1;
  assign interface_total_o = res.interface_total;

endmodule

// ----- sv/cdeb_front.sv -----
`timescale 1ns / 1ps
// Front part: configuration registers, descriptor byte parser and result builder.
// Depends on cdeb_pkg.
module cdeb_front #(
  parameter int MaxIfaces = 8,
  parameter int MaxEps    = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [19:0]         cfg_wdata_i,
  input  logic                accept_i,
  input  logic [7:0]          desc_byte_i,
  input  logic                final_byte_i,
  output cdeb_pkg::push_t     push_o
);

  logic [3:0]  port_speed_q;
  logic [7:0]  device_class_q;
  logic [19:0] route_string_q;

  logic [7:0]  byte_offset_q, byte_offset_d;
  logic [7:0]  cur_length_q, cur_length_d;
  logic [7:0]  cur_type_q, cur_type_d;
  logic [7:0]  field_q [5];
  logic [7:0]  field_d [5];
  logic        halted_q, halted_d;
  logic [3:0]  iface_count_q, iface_count_d;
  logic        iface_open_q, iface_open_d;
  logic [4:0]  ep_count_q, ep_count_d;
  logic [7:0]  first_class_q, first_class_d;
  logic [4:0]  top_index_q, top_index_d;
  logic [31:0] flag_mask_q, flag_mask_d;
  logic        pend_valid_q, pend_valid_d;
  logic [4:0]  pend_dci_q, pend_dci_d;
  logic [31:0] pend_info1_q, pend_info1_d;
  logic [31:0] pend_info2_q, pend_info2_d;
  logic [31:0] pend_tx_q, pend_tx_d;
  cdeb_pkg::comp_stage_e stage_q, stage_d;

  cdeb_pkg::res_t rec [2];
  logic [1:0]     cnt;

  always_comb begin
    logic [7:0]  b;
    logic [7:0]  off;
    logic [15:0] mps;
    logic [4:0]  dci;
    logic [1:0]  xfer;
    logic [2:0]  ep_type;
    logic [7:0]  interval;
    logic [1:0]  cerr;
    logic [15:0] esit;
    logic        hub;
    b = desc_byte_i;
    off = byte_offset_q;
    byte_offset_d = byte_offset_q;
    cur_length_d  = cur_length_q;
    cur_type_d    = cur_type_q;
    field_d       = field_q;
    halted_d      = halted_q;
    iface_count_d = iface_count_q;
    iface_open_d  = iface_open_q;
    ep_count_d    = ep_count_q;
    first_class_d = first_class_q;
    top_index_d   = top_index_q;
    flag_mask_d   = flag_mask_q;
    pend_valid_d  = pend_valid_q;
    pend_dci_d    = pend_dci_q;
    pend_info1_d  = pend_info1_q;
    pend_info2_d  = pend_info2_q;
    pend_tx_d     = pend_tx_q;
    stage_d       = stage_q;
    rec[0] = '0;
    rec[1] = '0;
    cnt = 2'd0;
    mps = '0; dci = '0; xfer = '0; ep_type = '0; interval = '0; cerr = '0; esit = '0;
    hub = 1'b0;
    if (!halted_q) begin
      if (pend_valid_d) begin
        case (stage_d)
          cdeb_pkg::CompLength: begin
            if (b < 8'd3) begin
              rec[cnt[0]] = cdeb_pkg::mk_ep(pend_dci_d, pend_info1_d, pend_info2_d, pend_tx_d);
              cnt = cnt + 2'd1;
              pend_valid_d = 1'b0;
              stage_d = cdeb_pkg::CompIdle;
            end else begin
              stage_d = cdeb_pkg::CompType;
            end
          end
          cdeb_pkg::CompType: begin
            if (b != cdeb_pkg::TypeCompanion) begin
              rec[cnt[0]] = cdeb_pkg::mk_ep(pend_dci_d, pend_info1_d, pend_info2_d, pend_tx_d);
              cnt = cnt + 2'd1;
              pend_valid_d = 1'b0;
              stage_d = cdeb_pkg::CompIdle;
            end else begin
              stage_d = cdeb_pkg::CompBurst;
            end
          end
          default: begin
            pend_info2_d = pend_info2_d | {16'h0000, b, 8'h00};
            rec[cnt[0]] = cdeb_pkg::mk_ep(pend_dci_d, pend_info1_d, pend_info2_d, pend_tx_d);
            cnt = cnt + 2'd1;
            pend_valid_d = 1'b0;
            stage_d = cdeb_pkg::CompIdle;
          end
        endcase
      end
      if (off == 8'd0) begin
        if (b < 8'd2) begin
          halted_d = 1'b1;
        end else begin
          cur_length_d  = b;
          byte_offset_d = 8'd1;
        end
      end else begin
        if (off == 8'd1) begin
          cur_type_d = b;
        end else if (off <= 8'd6) begin
          field_d[3'(off - 8'd2)] = b;
        end
        if (({1'b0, off} + 9'd1) >= {1'b0, cur_length_d}) begin
          byte_offset_d = 8'd0;
          if (cur_type_d == cdeb_pkg::TypeIface) begin
            if (cur_length_d >= 8'd9 && iface_count_d < 4'(MaxIfaces)) begin
              if (iface_count_d == 4'd0) begin
                first_class_d = field_d[3];
              end
              iface_count_d = iface_count_d + 4'd1;
              iface_open_d  = 1'b1;
              ep_count_d    = 5'd0;
            end
          end else if (cur_type_d == cdeb_pkg::TypeEndpoint && iface_open_d) begin
            if (cur_length_d >= 8'd7 && ep_count_d < 5'(MaxEps)) begin
              ep_count_d = ep_count_d + 5'd1;
              mps  = {field_d[3], field_d[2]};
              dci  = {field_d[0][3:0], field_d[0][7]};
              xfer = field_d[1][1:0];
              if (dci > top_index_d) begin
                top_index_d = dci;
              end
              flag_mask_d = flag_mask_d | (32'd1 << dci);
              ep_type = (xfer == 2'd0) ? 3'd4 : {field_d[0][7], xfer};
              interval = field_d[4];
              if (port_speed_q == cdeb_pkg::SpeedFull || port_speed_q == cdeb_pkg::SpeedLow)
              begin
                if (xfer == cdeb_pkg::XferIsoch) begin
                  interval = (field_d[4] != 8'd0) ? field_d[4] + 8'd3 : 8'd4;
                end else begin
                  interval = 8'd3;
                end
              end
              cerr = (xfer == cdeb_pkg::XferIsoch) ? 2'd0 : 2'd3;
              esit = (xfer == cdeb_pkg::XferIsoch) ? mps : 16'd0;
              pend_valid_d = 1'b1;
              pend_dci_d   = dci;
              pend_info1_d = {8'h00, interval, 16'h0000};
              pend_info2_d = {mps, 8'h00, 2'b00, ep_type, cerr, 1'b0};
              pend_tx_d    = {esit, mps};
              if (port_speed_q >= cdeb_pkg::SpeedSuper && !final_byte_i) begin
                stage_d = cdeb_pkg::CompLength;
              end else begin
                rec[cnt[0]] = cdeb_pkg::mk_ep(pend_dci_d, pend_info1_d, pend_info2_d,
                                              pend_tx_d);
                cnt = cnt + 2'd1;
                pend_valid_d = 1'b0;
                stage_d = cdeb_pkg::CompIdle;
              end
            end
          end
        end else begin
          byte_offset_d = off + 8'd1;
        end
      end
    end
    if (final_byte_i) begin
      if (pend_valid_d) begin
        rec[cnt[0]] = cdeb_pkg::mk_ep(pend_dci_d, pend_info1_d, pend_info2_d, pend_tx_d);
        cnt = cnt + 2'd1;
      end
      hub = (device_class_q == cdeb_pkg::ClassHub) ||
            (iface_count_d != 4'd0 && first_class_d == cdeb_pkg::ClassHub);
      rec[cnt[0]] = cdeb_pkg::mk_sum(flag_mask_d, top_index_d, hub, port_speed_q,
                                     route_string_q, iface_count_d);
      cnt = cnt + 2'd1;
      byte_offset_d = '0;
      cur_length_d  = '0;
      cur_type_d    = '0;
      halted_d      = 1'b0;
      iface_count_d = '0;
      iface_open_d  = 1'b0;
      ep_count_d    = '0;
      first_class_d = '0;
      top_index_d   = 5'd1;
      flag_mask_d   = 32'd1;
      pend_valid_d  = 1'b0;
      pend_dci_d    = '0;
      pend_info1_d  = '0;
      pend_info2_d  = '0;
      pend_tx_d     = '0;
      stage_d       = cdeb_pkg::CompIdle;
    end
    if (cnt == 2'd1) begin
      rec[0].run_last = 1'b1;
    end else if (cnt == 2'd2) begin
      rec[1].run_last = 1'b1;
    end
  end

  assign push_o.count = accept_i ? cnt : 2'd0;
  assign push_o.rec0  = rec[0];
  assign push_o.rec1  = rec[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      port_speed_q   <= cdeb_pkg::SpeedFull;
      device_class_q <= '0;
      route_string_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cdeb_pkg::cfg_idx_e'(cfg_idx_i))
        cdeb_pkg::CfgPortSpeed:   port_speed_q   <= cfg_wdata_i[3:0];
        cdeb_pkg::CfgDeviceClass: device_class_q <= cfg_wdata_i[7:0];
        cdeb_pkg::CfgRouteString: route_string_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_offset_q <= '0;
      cur_length_q  <= '0;
      cur_type_q    <= '0;
      halted_q      <= 1'b0;
      iface_count_q <= '0;
      iface_open_q  <= 1'b0;
      ep_count_q    <= '0;
      first_class_q <= '0;
      top_index_q   <= 5'd1;
      flag_mask_q   <= 32'd1;
      pend_valid_q  <= 1'b0;
      pend_dci_q    <= '0;
      pend_info1_q  <= '0;
      pend_info2_q  <= '0;
      pend_tx_q     <= '0;
      stage_q       <= cdeb_pkg::CompIdle;
    end else if (accept_i) begin
      byte_offset_q <= byte_offset_d;
      cur_length_q  <= cur_length_d;
      cur_type_q    <= cur_type_d;
      halted_q      <= halted_d;
      iface_count_q <= iface_count_d;
      iface_open_q  <= iface_open_d;
      ep_count_q    <= ep_count_d;
      first_class_q <= first_class_d;
      top_index_q   <= top_index_d;
      flag_mask_q   <= flag_mask_d;
      pend_valid_q  <= pend_valid_d;
      pend_dci_q    <= pend_dci_d;
      pend_info1_q  <= pend_info1_d;
      pend_info2_q  <= pend_info2_d;
      pend_tx_q     <= pend_tx_d;
      stage_q       <= stage_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      field_q <= field_d;
    end
  end

endmodule

// ----- sv/cdeb_queue.sv -----
`timescale 1ns / 1ps
// Four-entry result queue between front and back; takes up to two results a cycle.
// Depends on cdeb_pkg.
module cdeb_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  cdeb_pkg::push_t push_i,
  output logic            room_o,
  input  logic            pop_i,
  output logic            avail_o,
  output cdeb_pkg::res_t  head_o
);

  cdeb_pkg::res_t mem_q [4];
  logic [1:0] wr_ptr_q, wr_ptr_d;
  logic [1:0] rd_ptr_q, rd_ptr_d;
  logic [2:0] count_q, count_d;

  assign room_o  = count_q <= 3'd2;
  assign avail_o = count_q != 3'd0;
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q + push_i.count;
    rd_ptr_d = rd_ptr_q + {1'b0, pop_i};
    count_d  = count_q + {1'b0, push_i.count} - {2'b00, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.rec0;
    end
    if (push_i.count == 2'd2) begin
      mem_q[wr_ptr_q + 2'd1] <= push_i.rec1;
    end
  end

endmodule

// ----- sv/cdeb_back.sv -----
`timescale 1ns / 1ps
// Back part: output register that drains the result queue one transfer a cycle while not stalled.
// Depends on cdeb_pkg.
module cdeb_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           avail_i,
  input  cdeb_pkg::res_t head_i,
  output logic           pop_o,
  output logic           valid_o,
  input  logic           stall_i,
  output cdeb_pkg::res_t res_o
);

  logic           valid_q;
  cdeb_pkg::res_t res_q;

  assign pop_o   = avail_i && (!valid_q || !stall_i);
  assign valid_o = valid_q;
  assign res_o   = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!valid_q || !stall_i) begin
      valid_q <= avail_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      res_q <= head_i;
    end
  end

endmodule

// ----- sv/cdeb_checker.sv -----
`timescale 1ns / 1ps
// Port-level checker for the configuration descriptor endpoint builder, with bind.
// Depends on config_descriptor_endpoint_builder_top.
module cdeb_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        kind_o,
  input logic        run_last_o,
  input logic [4:0]  ep_dci_o,
  input logic [31:0] ep_info2_o,
  input logic [31:0] ctx_add_mask_o,
  input logic [4:0]  max_index_o,
  input logic [31:0] slot_info1_o
);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(ep_info2_o) && $stable(kind_o))
    else $error("stalled transfer changed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o |-> run_last_o)
    else $error("summary not last of its byte");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o |-> ep_dci_o == 5'd0 && ep_info2_o == 32'd0 &&
      ctx_add_mask_o[0] && max_index_o != 5'd0 && slot_info1_o[31:27] == max_index_o)
    else $error("malformed summary");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !kind_o |-> ctx_add_mask_o == 32'd0 && slot_info1_o == 32'd0)
    else $error("endpoint carries summary fields");

endmodule

bind config_descriptor_endpoint_builder_top cdeb_checker u_cdeb_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .kind_o        (kind_o),
  .run_last_o    (run_last_o),
  .ep_dci_o      (ep_dci_o),
  .ep_info2_o    (ep_info2_o),
  .ctx_add_mask_o(ctx_add_mask_o),
  .max_index_o   (max_index_o),
  .slot_info1_o  (slot_info1_o)
);

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps
// Testbench for config_descriptor_endpoint_builder_top: drives descriptor byte
// streams, predicts endpoint and summary results, checks them in order.
// Depends on cdeb_pkg and the block's RTL.
module tb_top;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = '0;
  logic [19:0] cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  desc_byte_i = '0;
  logic        final_byte_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        kind_o, run_last_o, hub_flag_o;
  logic [4:0]  ep_dci_o, max_index_o;
  logic [31:0] ep_info1_o, ep_info2_o, ep_tx_info_o, ctx_add_mask_o, slot_info1_o;
  logic [3:0]  interface_total_o;

  config_descriptor_endpoint_builder_top u_dut (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  cdeb_pkg::res_t exp_results[$];
  int             errors = 0;
  int             hold_cycles = 0;
  bit             rand_stall = 1'b1;

  // predictor state
  logic [3:0]  m_speed;
  logic [7:0]  m_class;
  logic [19:0] m_route;
  logic [7:0]  m_off, m_len, m_type;
  logic [7:0]  m_fld[5];
  logic        m_halt, m_open, m_pend;
  logic [3:0]  m_ifc;
  logic [4:0]  m_epc, m_top, m_pdci;
  logic [7:0]  m_fclass;
  logic [31:0] m_flags, m_pi1, m_pi2, m_ptx;
  cdeb_pkg::comp_stage_e m_stage;

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    errors++;
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
  endtask

  function automatic void clear_parse();
    m_off = '0; m_len = '0; m_type = '0;
    foreach (m_fld[i]) m_fld[i] = '0;
    m_halt = 1'b0; m_ifc = '0; m_open = 1'b0; m_epc = '0; m_fclass = '0;
    m_top = 5'd1; m_flags = 32'd1; m_pend = 1'b0; m_pdci = '0;
    m_pi1 = '0; m_pi2 = '0; m_ptx = '0; m_stage = cdeb_pkg::CompIdle;
  endfunction

  function automatic void push_endpoint();
    cdeb_pkg::res_t r;
    r = '0;
    r.ep_dci = m_pdci; r.ep_info1 = m_pi1; r.ep_info2 = m_pi2; r.ep_tx_info = m_ptx;
    exp_results.push_back(r);
    m_pend = 1'b0; m_stage = cdeb_pkg::CompIdle;
  endfunction

  function automatic void push_summary();
    cdeb_pkg::res_t r;
    logic hub;
    hub = (m_class == cdeb_pkg::ClassHub) || (m_ifc > 0 && m_fclass == cdeb_pkg::ClassHub);
    r = '0;
    r.kind = 1'b1; r.ctx_add_mask = m_flags; r.max_index = m_top; r.hub_flag = hub;
    r.slot_info1 = {m_top, hub, 2'b00, m_speed, m_route};
    r.interface_total = m_ifc;
    exp_results.push_back(r);
  endfunction

  function automatic void build_endpoint();
    logic [7:0]  addr, bint;
    logic [1:0]  xfer;
    logic [15:0] mps;
    logic        din;
    logic [4:0]  dci;
    logic [2:0]  etype;
    logic [7:0]  ival;
    addr = m_fld[0]; xfer = m_fld[1][1:0]; mps = {m_fld[3], m_fld[2]}; bint = m_fld[4];
    din = addr[7];
    dci = {addr[3:0], din};
    if (dci > m_top) m_top = dci;
    m_flags[dci] = 1'b1;
    etype = (xfer == 2'd0) ? 3'd4 : {din, xfer};
    ival = bint;
    if (m_speed == cdeb_pkg::SpeedFull || m_speed == cdeb_pkg::SpeedLow)
      ival = (xfer == cdeb_pkg::XferIsoch) ? ((bint != 8'd0) ? bint + 8'd3 : 8'd4) : 8'd3;
    m_pend = 1'b1; m_pdci = dci;
    m_pi1 = {8'h0, ival, 16'h0};
    m_pi2 = {mps, 8'h0, 2'b0, etype, (xfer == cdeb_pkg::XferIsoch) ? 2'd0 : 2'd3, 1'b0};
    m_ptx = {(xfer == cdeb_pkg::XferIsoch) ? mps : 16'h0, mps};
  endfunction

  function automatic void predict_byte(input logic [7:0] b, input logic fin);
    int n0;
    n0 = exp_results.size();
    if (!m_halt) begin
      if (m_pend) begin
        case (m_stage)
          cdeb_pkg::CompLength: begin
            if (b < 8'd3) push_endpoint(); else m_stage = cdeb_pkg::CompType;
          end
          cdeb_pkg::CompType: begin
            if (b != cdeb_pkg::TypeCompanion) push_endpoint();
            else m_stage = cdeb_pkg::CompBurst;
          end
          default: begin
            m_pi2[15:8] = m_pi2[15:8] | b;
            push_endpoint();
          end
        endcase
      end
      if (m_off == 8'd0) begin
        if (b < 8'd2) m_halt = 1'b1;
        else begin
          m_len = b; m_off = 8'd1;
        end
      end else begin
        if (m_off == 8'd1) m_type = b;
        else if (m_off <= 8'd6) m_fld[3'(m_off - 8'd2)] = b;
        if (9'(m_off) + 9'd1 >= 9'(m_len)) begin
          m_off = 8'd0;
          if (m_type == cdeb_pkg::TypeIface) begin
            if (m_len >= 8'd9 && m_ifc < 4'd8) begin
              if (m_ifc == 4'd0) m_fclass = m_fld[3];
              m_ifc++; m_open = 1'b1; m_epc = '0;
            end
          end else if (m_type == cdeb_pkg::TypeEndpoint && m_open) begin
            if (m_len >= 8'd7 && m_epc < 5'd16) begin
              m_epc++;
              build_endpoint();
              if (m_speed >= cdeb_pkg::SpeedSuper && !fin) m_stage = cdeb_pkg::CompLength;
              else push_endpoint();
            end
          end
        end else m_off = m_off + 8'd1;
      end
    end
    if (fin) begin
      if (m_pend) push_endpoint();
      push_summary();
      clear_parse();
    end
    if (exp_results.size() > n0) exp_results[$].run_last = 1'b1;
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic fin);
    in_valid_i <= 1'b1;
    desc_byte_i <= b;
    final_byte_i <= fin;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_byte(b, fin);
    @(negedge clk_i);
    if ($urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (exp_results.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_cfg(input cdeb_pkg::cfg_idx_e idx, input logic [19:0] v);
    drain();
    cfg_we_i <= 1'b1; cfg_idx_i <= idx; cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      cdeb_pkg::CfgPortSpeed:   m_speed = v[3:0];
      cdeb_pkg::CfgDeviceClass: m_class = v[7:0];
      cdeb_pkg::CfgRouteString: m_route = v;
      default: ;
    endcase
  endtask

  task automatic send_iface(input logic [7:0] cls, input logic [7:0] len);
    send_byte(len, 1'b0); send_byte(cdeb_pkg::TypeIface, 1'b0);
    for (int i = 2; i < len; i++) send_byte((i == 5) ? cls : 8'($urandom), 1'b0);
  endtask

  task automatic send_ep(input logic [7:0] len, input logic [7:0] addr,
                         input logic [7:0] attr, input logic [15:0] mps,
                         input logic [7:0] ival);
    send_byte(len, 1'b0); send_byte(cdeb_pkg::TypeEndpoint, 1'b0);
    send_byte(addr, 1'b0); send_byte(attr, 1'b0);
    send_byte(mps[7:0], 1'b0); send_byte(mps[15:8], 1'b0); send_byte(ival, 1'b0);
    for (int i = 7; i < len; i++) send_byte(8'($urandom), 1'b0);
  endtask

  task automatic send_companion(input logic [7:0] burst);
    send_byte(8'd6, 1'b0); send_byte(cdeb_pkg::TypeCompanion, 1'b0);
    send_byte(burst, 1'b0);
    send_byte(8'($urandom), 1'b0); send_byte(8'($urandom), 1'b0);
    send_byte(8'($urandom), 1'b0);
  endtask

  task automatic test_directed();
    send_iface(cdeb_pkg::ClassHub, 8'd9);
    send_ep(8'd7, 8'h81, 8'h01, 16'hFFFF, 8'h00);
    send_ep(8'd7, 8'h0F, 8'h00, 16'h0000, 8'hFF);
    send_ep(8'd5, 8'h82, 8'h02, 16'h0040, 8'h01);
    send_byte(8'd1, 1'b0);
    send_byte(8'hAA, 1'b1);
  endtask

  task automatic test_super();
    send_iface(8'h03, 8'd9);
    send_ep(8'd7, 8'h81, 8'h03, 16'h0400, 8'h04);
    send_companion(8'hFF);
    send_ep(8'd7, 8'h02, 8'h01, 16'h0200, 8'h00);
    send_byte(8'd2, 1'b0); send_byte(8'h21, 1'b0);
    send_ep(8'd7, 8'h83, 8'h02, 16'h0400, 8'h00);
    send_byte(8'd3, 1'b0); send_byte(8'h31, 1'b0); send_byte(8'd0, 1'b0);
    send_ep(8'd7, 8'h84, 8'h02, 16'h0400, 8'h00);
    send_byte(8'd6, 1'b0); send_byte(cdeb_pkg::TypeCompanion, 1'b1);
  endtask

  task automatic send_random_config(input int n);
    int k;
    for (int c = 0; c < n; c++) begin
      k = $urandom_range(0, 19);
      if (k == 0) send_byte(8'($urandom), 1'($urandom_range(0, 1)));
      else if (k < 4) send_iface(8'($urandom_range(8, 10)), $urandom_range(0, 3) ? 8'd9 : 8'd7);
      else if (k < 14) begin
        send_ep($urandom_range(0, 5) ? 8'd7 : 8'($urandom_range(2, 8)), 8'($urandom),
                8'($urandom), 16'($urandom), 8'($urandom));
        if (m_speed >= cdeb_pkg::SpeedSuper && $urandom_range(0, 1))
          send_companion(8'($urandom));
      end else if (k < 16) send_companion(8'($urandom));
      else if (k == 16) send_byte(8'($urandom_range(0, 1)), 1'b0);
      else send_byte(8'($urandom_range(2, 4)), 1'b0);
    end
    send_byte(8'($urandom), 1'b1);
  endtask

  task automatic test_random();
    for (int p = 0; p < 6; p++) begin
      write_cfg(cdeb_pkg::CfgPortSpeed, (p == 5) ? 20'hF : 20'($urandom_range(0, 5)));
      write_cfg(cdeb_pkg::CfgDeviceClass, 20'($urandom_range(8, 10)));
      write_cfg(cdeb_pkg::CfgRouteString, 20'($urandom));
      send_random_config($urandom_range(6, 14));
    end
  endtask

  task automatic test_backpressure();
    rand_stall = 1'b0;
    hold_cycles = 60;
    send_iface(8'h00, 8'd9);
    for (int i = 0; i < 6; i++) send_ep(8'd7, 8'(i), 8'h01, 16'h10, 8'h1);
    send_byte(8'd0, 1'b1);
    drain();
    rand_stall = 1'b1;
  endtask

  // receiver stall pattern
  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      hold_cycles--;
      out_stall_i <= 1'b1;
    end else out_stall_i <= rand_stall && ($urandom_range(0, 3) == 0);
  end

  always @(posedge clk_i) begin
    cdeb_pkg::res_t w;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (exp_results.size() == 0) begin
        report("unexpected result", 32'd1, 32'd0);
      end else begin
        w = exp_results.pop_front();
        if (kind_o !== w.kind) report("kind", 32'(kind_o), 32'(w.kind));
        if (run_last_o !== w.run_last) report("run_last", 32'(run_last_o), 32'(w.run_last));
        if (ep_dci_o !== w.ep_dci) report("ep_dci", 32'(ep_dci_o), 32'(w.ep_dci));
        if (ep_info1_o !== w.ep_info1) report("ep_info1", ep_info1_o, w.ep_info1);
        if (ep_info2_o !== w.ep_info2) report("ep_info2", ep_info2_o, w.ep_info2);
        if (ep_tx_info_o !== w.ep_tx_info) report("ep_tx_info", ep_tx_info_o, w.ep_tx_info);
        if (ctx_add_mask_o !== w.ctx_add_mask)
          report("ctx_add_mask", ctx_add_mask_o, w.ctx_add_mask);
        if (max_index_o !== w.max_index)
          report("max_index", 32'(max_index_o), 32'(w.max_index));
        if (hub_flag_o !== w.hub_flag) report("hub_flag", 32'(hub_flag_o), 32'(w.hub_flag));
        if (slot_info1_o !== w.slot_info1) report("slot_info1", slot_info1_o, w.slot_info1);
        if (interface_total_o !== w.interface_total)
          report("interface_total", 32'(interface_total_o), 32'(w.interface_total));
      end
    end
  end

  initial begin
    #2000000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    m_speed = cdeb_pkg::SpeedFull; m_class = '0; m_route = '0;
    clear_parse();
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    write_cfg(cdeb_pkg::CfgPortSpeed, 20'(cdeb_pkg::SpeedLow));
    write_cfg(cdeb_pkg::CfgDeviceClass, 20'hFF);
    write_cfg(cdeb_pkg::CfgRouteString, 20'hFFFFF);
    test_directed();
    write_cfg(cdeb_pkg::CfgPortSpeed, 20'(cdeb_pkg::SpeedSuper));
    test_super();
    test_backpressure();
    test_random();
    drain();
    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end
endmodule
